// ===== hw/rtl/rle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_pkg: shared types and codes for the RANSAC line extractor
// Command and status codes and the interface structs of the divider.
// ----------------------------------------------------------------------------
package rle_pkg;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_TRY   = 2'd2;

	localparam logic [1:0] ST_ACCEPT = 2'd0;
	localparam logic [1:0] ST_FEW    = 2'd1;
	localparam logic [1:0] ST_BAD    = 2'd2;
	localparam logic [1:0] ST_DEGEN  = 2'd3;

	localparam int NORM_EXTRA = 7;
	localparam int CFG_THRESH = 0;
	localparam int CFG_MININL = 1;

	localparam int DIV_W = 72;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quo;
	} div_rsp_t;

endpackage

// ===== hw/rtl/rle_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module rle_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// ===== hw/rtl/rle_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_div: restoring unsigned divider
// Produces one quotient bit per cycle; the square root steps stay in the
// sequencer, this unit does division only.
// ----------------------------------------------------------------------------
module rle_div (
	input  logic             clk,
	input  logic             arst_n,
	input  rle_pkg::div_req_t req,
	output rle_pkg::div_rsp_t rsp
);
	import rle_pkg::*;

	logic [DIV_W-1:0]         rem_q, quo_q, den_q;
	logic [$clog2(DIV_W):0]   cnt_q;
	logic                     busy_q, done_q;
	logic [DIV_W:0]           trial;

	assign trial = {rem_q, quo_q[DIV_W-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(DIV_W)+1)'(DIV_W-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[DIV_W]) begin
				rem_q <= trial[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DIV_W-2:0], quo_q[DIV_W-1]};
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule

// ===== hw/rtl/ransac_line_extraction.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ransac_line_extraction: sequential RANSAC line extractor
// A start passes through a clear state, a load is stored from idle. A trial
// runs its setup (point reads, four products, a square root, three
// divisions), counts inliers over the N stored points, marks the inliers
// of an accepted line and raises the result; a rejected pair skips to it.
// One transaction at a time; a result waits in the output register.
// Reset clears counters and sequencer, presets config; a load clears the used
// mark of its entry, so start needs no clearing pass. Stores stay undefined.
// ----------------------------------------------------------------------------
module ransac_line_extraction #(
	parameter int MAX_POINTS = 1024,
	parameter int FRAC_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// cmd[1:0], point_x[25:2], point_y[49:26], first_index[59:50],
	// second_index[69:60], zero fill
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[1:0], line_a[19:2], line_b[37:20], line_c[62:38],
	// inlier_count[73:63], line_number[83:74], zero fill
	output logic [87:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);
	import rle_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = AW + 1;
	localparam int IW = (CW > 10) ? CW : 10;

	typedef enum logic [14:0] {
		S_IDLE  = 15'h0001, S_CLR   = 15'h0002, S_RD1   = 15'h0004,
		S_RD2   = 15'h0008, S_CHK   = 15'h0010, S_MUL   = 15'h0020,
		S_SQRT  = 15'h0040, S_DIVA  = 15'h0080, S_DIVB  = 15'h0100,
		S_DIVC  = 15'h0200, S_SCAN  = 15'h0400, S_DEC   = 15'h0800,
		S_MARK  = 15'h1000, S_OUT   = 15'h2000, S_WAIT  = 15'h4000
	} state_t;

	state_t state_q;

	logic [15:0] thr_q;
	logic [10:0] minin_q;
	logic [CW-1:0] loaded_q;
	logic [9:0]  lines_q;

	logic [1:0]  cmd;
	logic signed [23:0] in_x, in_y;
	logic [9:0]  in_i1, in_i2;
	assign cmd   = s_axis_tdata[1:0];
	assign in_x  = s_axis_tdata[25:2];
	assign in_y  = s_axis_tdata[49:26];
	assign in_i1 = s_axis_tdata[59:50];
	assign in_i2 = s_axis_tdata[69:60];

	logic s_acc;
	assign s_axis_tready = (state_q == S_IDLE) && !m_axis_tvalid;
	assign s_acc = s_axis_tvalid && s_axis_tready;

	// point stores
	logic              ram_we;
	logic [AW-1:0]     ram_addr;
	logic [23:0]       xr, yr;
	rle_ram #(.WIDTH(24), .DEPTH(MAX_POINTS)) u_xram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in_x), .rdata(xr));
	rle_ram #(.WIDTH(24), .DEPTH(MAX_POINTS)) u_yram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in_y), .rdata(yr));

	logic [9:0]  i1_q, i2_q;
	logic signed [24:0] a_q, b_q;
	logic signed [48:0] c_q;
	logic signed [23:0] x1_q, y1_q;
	logic        u1_q;
	logic [50:0] s_q;
	logic [63:0] sq_v_q, sq_res_q, sq_bit_q;
	logic [31:0] r_q;
	logic signed [17:0] an_q, bn_q;
	logic signed [24:0] cn_q;
	logic [CW-1:0] idx_q;
	logic [10:0] count_q;
	logic [1:0]  st_q;
	logic [1:0]  mph_q;
	logic        issued_q;

	// shared multiplier, one product per cycle
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p_q;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MUL: begin
				unique case (mph_q)
					2'd0: begin mul_a = 32'(a_q); mul_b = 32'(a_q); end
					2'd1: begin mul_a = 32'(b_q); mul_b = 32'(b_q); end
					2'd2: begin mul_a = 32'($signed(xr)); mul_b = 32'(y1_q); end
					default: begin mul_a = 32'(x1_q); mul_b = 32'($signed(yr)); end
				endcase
			end
			default: ;
		endcase
	end
	always_ff @(posedge clk) mul_p_q <= mul_a * mul_b;

	// divider
	div_req_t dreq;
	div_rsp_t drsp;
	logic signed [DIV_W-1:0] num_s;
	logic [DIV_W-1:0] num_mag;
	always_comb begin
		num_s = '0;
		unique case (state_q)
			S_DIVA: num_s = DIV_W'(a_q) <<< (FRAC_BITS + NORM_EXTRA);
			S_DIVB: num_s = DIV_W'(b_q) <<< (FRAC_BITS + NORM_EXTRA);
			S_DIVC: num_s = DIV_W'(c_q) <<< NORM_EXTRA;
			default: num_s = '0;
		endcase
		num_mag = num_s[DIV_W-1] ? DIV_W'(-num_s) : DIV_W'(num_s);
	end
	assign dreq.start = !issued_q && (state_q == S_DIVA || state_q == S_DIVB
		|| state_q == S_DIVC);
	assign dreq.num = num_mag + DIV_W'(r_q >> 1);
	assign dreq.den = DIV_W'(r_q);
	rle_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic signed [DIV_W-1:0] qs;
	assign qs = num_s[DIV_W-1] ? -$signed(drsp.quo) : $signed(drsp.quo);
	localparam longint LIM = (FRAC_BITS >= 17) ? 131071 : (64'sd1 <<< FRAC_BITS);
	function automatic logic signed [17:0] clamp_ab(input logic signed [DIV_W-1:0] v);
		if (v > DIV_W'(LIM)) return 18'(LIM);
		if (v < -DIV_W'(LIM)) return 18'(-LIM);
		return 18'(v);
	endfunction

	// inlier test on the point read last cycle
	logic signed [63:0] dsum;
	logic [63:0] dmag;
	logic        inl;
	logic        ok_idx;
	assign dsum = 64'(an_q) * 64'($signed(xr)) + 64'(bn_q) * 64'($signed(yr))
		+ (64'(cn_q) <<< FRAC_BITS);
	assign dmag = dsum[63] ? -dsum : dsum;
	assign inl  = dmag < (64'(thr_q) << FRAC_BITS);
	assign ok_idx = i1_q != i2_q && IW'(i1_q) < IW'(loaded_q)
		&& IW'(i2_q) < IW'(loaded_q);

	logic [AW-1:0] pidx;
	assign pidx = AW'(idx_q - 1'b1);

	logic [63:0] sq_sum;
	assign sq_sum = sq_res_q + sq_bit_q;

	always_comb begin
		ram_we   = 1'b0;
		ram_addr = AW'(in_i1);
		unique case (state_q)
			S_IDLE: begin
				ram_we   = s_acc && cmd == CMD_LOAD && loaded_q < CW'(MAX_POINTS);
				ram_addr = ram_we ? AW'(loaded_q) : AW'(in_i1);
			end
			S_RD1:  ram_addr = AW'(i1_q);
			S_SCAN, S_MARK: ram_addr = AW'(idx_q);
			default: ram_addr = AW'(i2_q);
		endcase
	end

	// used marks: a load clears its entry, marking sets the entry read last cycle
	logic          used_we, used_wd, used_rd;
	logic [AW-1:0] used_addr;
	assign used_we   = ram_we || (state_q == S_MARK && idx_q != 0 && inl);
	assign used_wd   = (state_q == S_MARK);
	assign used_addr = (state_q == S_MARK) ? pidx : ram_addr;
	rle_ram #(.WIDTH(1), .DEPTH(MAX_POINTS)) u_used (
		.clk(clk), .we(used_we), .addr(used_addr), .wdata(used_wd), .rdata(used_rd));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			thr_q    <= 16'd786;
			minin_q  <= 11'd8;
			loaded_q <= '0;
			lines_q  <= '0;
			m_axis_tvalid <= 1'b0;
			idx_q    <= '0;
			issued_q <= 1'b0;
			mph_q    <= '0;
			count_q  <= '0;
			st_q     <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == 1'(CFG_THRESH)) thr_q <= cfg_wdata;
				else minin_q <= cfg_wdata[10:0];
			end
			if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (s_acc) begin
					i1_q <= in_i1;
					i2_q <= in_i2;
					unique case (cmd)
						CMD_START: begin
							loaded_q <= '0;
							lines_q  <= '0;
							state_q  <= S_CLR;
						end
						CMD_LOAD: if (loaded_q < CW'(MAX_POINTS))
							loaded_q <= loaded_q + 1'b1;
						CMD_TRY: state_q <= S_RD1;
						default: ;
					endcase
				end
				S_CLR: state_q <= S_IDLE;
				S_RD1: state_q <= S_RD2;
				S_RD2: begin
					x1_q <= $signed(xr);
					y1_q <= $signed(yr);
					u1_q <= used_rd;
					state_q <= S_CHK;
				end
				S_CHK: begin
					a_q <= 25'($signed(yr)) - 25'(y1_q);
					b_q <= 25'(x1_q) - 25'($signed(xr));
					count_q <= '0;
					an_q <= '0; bn_q <= '0; cn_q <= '0;
					if (!ok_idx || u1_q || used_rd) begin
						st_q <= ST_BAD;
						state_q <= S_OUT;
					end else if (xr == x1_q && yr == y1_q) begin
						st_q <= ST_DEGEN;
						state_q <= S_OUT;
					end else begin
						mph_q <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					mph_q <= mph_q + 1'b1;
					unique case (mph_q)
						2'd1: s_q <= 51'(mul_p_q);
						2'd2: s_q <= s_q + 51'(mul_p_q);
						2'd3: c_q <= 49'(mul_p_q);
						default: ;
					endcase
					if (mph_q == 2'd3) begin
						sq_bit_q <= 64'd1 << 62;
						sq_res_q <= '0;
						state_q  <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (mph_q == 2'd0) begin
						c_q <= c_q - 49'(mul_p_q);
						sq_v_q <= 64'(s_q) << 14;
						mph_q <= 2'd1;
					end else if (sq_bit_q == 0) begin
						r_q <= 32'(sq_res_q);
						issued_q <= 1'b0;
						state_q <= S_DIVA;
					end else begin
						if (sq_v_q >= sq_sum) begin
							sq_v_q   <= sq_v_q - sq_sum;
							sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
						end else sq_res_q <= sq_res_q >> 1;
						sq_bit_q <= sq_bit_q >> 2;
					end
				end
				S_DIVA, S_DIVB, S_DIVC: begin
					if (drsp.done && issued_q) begin
						issued_q <= 1'b0;
						if (state_q == S_DIVA) begin
							an_q <= clamp_ab(qs); state_q <= S_DIVB;
						end else if (state_q == S_DIVB) begin
							bn_q <= clamp_ab(qs); state_q <= S_DIVC;
						end else begin
							if (qs > DIV_W'(16777215)) cn_q <= 25'sd16777215;
							else if (qs < -DIV_W'(16777216)) cn_q <= -25'sd16777216;
							else cn_q <= 25'(qs);
							idx_q <= '0;
							state_q <= S_SCAN;
						end
					end else issued_q <= 1'b1;
				end
				S_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q != 0 && !used_rd && inl)
						count_q <= count_q + 1'b1;
					if (idx_q >= loaded_q) state_q <= S_DEC;
				end
				S_DEC: begin
					idx_q <= '0;
					if (count_q >= minin_q) begin
						st_q <= ST_ACCEPT;
						if (lines_q != 10'd1023) lines_q <= lines_q + 1'b1;
						state_q <= S_MARK;
					end else begin
						st_q <= ST_FEW;
						state_q <= S_OUT;
					end
				end
				S_MARK: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q >= loaded_q) state_q <= S_OUT;
				end
				S_OUT: begin
					m_axis_tvalid <= 1'b1;
					state_q <= S_WAIT;
				end
				S_WAIT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tdata = {4'd0,
		(st_q == ST_ACCEPT) ? lines_q : 10'd0,
		count_q, cn_q, bn_q, an_q, st_q};

	a_valid_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("ready with pending result");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(count_q) <= loaded_q
		|| (state_q != S_SCAN && state_q != S_DEC && state_q != S_MARK))
		else $error("count overrun");
	a_load_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= CW'(MAX_POINTS)) else $error("load count overflow");
endmodule

// ===== test/tb_ransac_line_extraction.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ransac_line_extraction: self-checking bench for the RANSAC line extractor
// Scans of points are loaded and index pairs tried against an in-bench
// predictor of the line fit, inlier count and used marks. Results are
// compared field by field under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_ransac_line_extraction;
	import rle_pkg::*;

	localparam int      NPTS      = 1024;
	localparam longint  ONE       = 64'sd65536;
	localparam int      SETTLE    = 2500;
	localparam longint  CYC_LIMIT = 4000000;

	typedef struct {
		logic [1:0]         cmd;
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic [9:0]         i1;
		logic [9:0]         i2;
	} scan_cmd_t;

	typedef struct {
		logic [1:0]         status;
		logic signed [17:0] a;
		logic signed [17:0] b;
		logic signed [24:0] c;
		logic [10:0]        cnt;
		logic [9:0]         num;
	} line_res_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [87:0] m_axis_tdata;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [15:0] cfg_wdata;

	scan_cmd_t pending_cmds[$];
	line_res_t expected_lines[$];
	scan_cmd_t cur_cmd;
	bit        offering;
	int        send_idle_pct;
	int        recv_stall_pct;
	int        hold_req;
	int        hold_seen;
	int        hold_cnt;
	int        errors;
	longint    cycles;

	int        xs[NPTS];
	int        ys[NPTS];
	bit        used[NPTS];
	int        n_loaded;
	int        n_lines;
	int        thr;
	int        min_inl;

	ransac_line_extraction dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned res, bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > v) bt = bt >> 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v = v - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	function automatic longint div_near(longint num, longint unsigned den);
		longint unsigned mag, q;
		mag = num < 0 ? -num : num;
		q = (mag + den / 2) / den;
		return num < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic bit near_line(int i, longint a, longint b, longint c);
		longint d;
		d = a * xs[i] + b * ys[i] + c * ONE;
		if (d < 0) d = -d;
		return d < longint'(thr) * ONE;
	endfunction

	// Update the scan state for one accepted command; queue the line result of a trial.
	function automatic void fit_line(scan_cmd_t t);
		line_res_t r;
		longint x1, y1, x2, y2, ca, cb, cc, an, bn, cn;
		longint unsigned s, rt;
		int cnt;
		r = '{default: '0};
		cnt = 0;
		case (t.cmd)
			CMD_START: begin
				foreach (used[i]) used[i] = 1'b0;
				n_loaded = 0;
				n_lines = 0;
			end
			CMD_LOAD: begin
				if (n_loaded < NPTS) begin
					xs[n_loaded] = t.px;
					ys[n_loaded] = t.py;
					n_loaded++;
				end
			end
			CMD_TRY: begin
				if (t.i1 == t.i2 || t.i1 >= n_loaded || t.i2 >= n_loaded ||
						used[t.i1] || used[t.i2]) begin
					r.status = ST_BAD;
				end else begin
					x1 = xs[t.i1]; y1 = ys[t.i1];
					x2 = xs[t.i2]; y2 = ys[t.i2];
					ca = y2 - y1;
					cb = x1 - x2;
					if (ca == 0 && cb == 0) begin
						r.status = ST_DEGEN;
					end else begin
						cc = x2 * y1 - x1 * y2;
						s = ca * ca + cb * cb;
						rt = isqrt(s << 14);
						an = clip(div_near(ca <<< 23, rt), -ONE, ONE);
						bn = clip(div_near(cb <<< 23, rt), -ONE, ONE);
						cn = clip(div_near(cc <<< NORM_EXTRA, rt), -16777216, 16777215);
						for (int i = 0; i < n_loaded; i++)
							if (!used[i] && near_line(i, an, bn, cn)) cnt++;
						if (cnt >= min_inl) begin
							for (int i = 0; i < n_loaded; i++)
								if (!used[i] && near_line(i, an, bn, cn)) used[i] = 1'b1;
							if (n_lines < 1023) n_lines++;
							r.num = n_lines;
							r.status = ST_ACCEPT;
						end else begin
							r.status = ST_FEW;
						end
						r.a = an;
						r.b = bn;
						r.c = cn;
						r.cnt = cnt;
					end
				end
				expected_lines.push_back(r);
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			offering = 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				fit_line(cur_cmd);
				offering = 1'b0;
			end
			if (!offering && pending_cmds.size() > 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				cur_cmd = pending_cmds.pop_front();
				offering = 1'b1;
			end
			s_axis_tvalid <= offering;
			s_axis_tdata <= {2'b00, cur_cmd.i2, cur_cmd.i1, cur_cmd.py, cur_cmd.px,
				cur_cmd.cmd};
		end
	end

	always @(posedge clk or negedge arst_n) begin
		line_res_t e;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_seen = 0;
			hold_cnt = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_lines.size() == 0) begin
					$error("unexpected result transaction %h", m_axis_tdata);
					errors++;
				end else begin
					e = expected_lines.pop_front();
					if (m_axis_tdata[1:0] !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, m_axis_tdata[1:0]);
						errors++;
					end
					if ($signed(m_axis_tdata[19:2]) !== e.a) begin
						$error("line_a: expected %0d, got %0d", e.a,
							$signed(m_axis_tdata[19:2]));
						errors++;
					end
					if ($signed(m_axis_tdata[37:20]) !== e.b) begin
						$error("line_b: expected %0d, got %0d", e.b,
							$signed(m_axis_tdata[37:20]));
						errors++;
					end
					if ($signed(m_axis_tdata[62:38]) !== e.c) begin
						$error("line_c: expected %0d, got %0d", e.c,
							$signed(m_axis_tdata[62:38]));
						errors++;
					end
					if (m_axis_tdata[73:63] !== e.cnt) begin
						$error("inlier_count: expected %0d, got %0d", e.cnt,
							m_axis_tdata[73:63]);
						errors++;
					end
					if (m_axis_tdata[83:74] !== e.num) begin
						$error("line_number: expected %0d, got %0d", e.num,
							m_axis_tdata[83:74]);
						errors++;
					end
				end
			end
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_cnt = 4000;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYC_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic push_cmd(logic [1:0] c, int x, int y, int a, int b);
		scan_cmd_t t;
		t.cmd = c;
		t.px = 24'(x);
		t.py = 24'(y);
		t.i1 = 10'(a);
		t.i2 = 10'(b);
		pending_cmds.push_back(t);
	endtask

	task automatic drain();
		while (pending_cmds.size() > 0 || offering || expected_lines.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(int idx, int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= 1'(idx);
		cfg_wdata <= 16'(val);
		if (idx == CFG_THRESH) thr = val & 16'hFFFF;
		else min_inl = val & 11'h7FF;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Push a scan: a noisy cluster along a random line, stray points, then trials mixed with unused command codes.
	task automatic push_scan(int n, int ntry, ref int made);
		int x0, y0, dx, dy, nz, lo;
		x0 = $urandom_range(4000000) - 2000000;
		y0 = $urandom_range(4000000) - 2000000;
		dx = $urandom_range(80000) - 40000;
		dy = $urandom_range(80000) - 40000;
		nz = $urandom_range(1200);
		push_cmd(CMD_START, 0, 0, 0, 0);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(99) < 65)
				push_cmd(CMD_LOAD, x0 + k * dx + int'($urandom_range(2 * nz)) - nz,
					y0 + k * dy + int'($urandom_range(2 * nz)) - nz, $urandom, $urandom);
			else
				push_cmd(CMD_LOAD, $urandom, $urandom, $urandom, $urandom);
		end
		made += n + 1;
		for (int k = 0; k < ntry; k++) begin
			lo = $urandom_range(99);
			if (lo < 5)
				push_cmd(2'd3, $urandom, $urandom, $urandom, $urandom);
			else if (lo < 20)
				push_cmd(CMD_TRY, $urandom, $urandom, $urandom, $urandom);
			else
				push_cmd(CMD_TRY, $urandom, $urandom, $urandom_range(n - 1),
					$urandom_range(n - 1));
		end
		made += ntry;
	endtask

	initial begin
		int made, ph;
		int thr_set[5] = '{786, 0, 65535, 3000, 20000};
		int min_set[5] = '{8, 0, 1024, 1, 16'hF802};
		int send_set[4] = '{0, 72, 0, 23};
		int stall_set[4] = '{0, 0, 72, 23};
		errors = 0;
		cycles = 0;
		hold_req = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		thr = 786;
		min_inl = 8;
		n_loaded = 0;
		n_lines = 0;
		foreach (used[i]) used[i] = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: nine collinear points, extremes, a duplicate
		push_cmd(CMD_START, 0, 0, 0, 0);
		for (int k = 0; k < 9; k++)
			push_cmd(CMD_LOAD, k * 65536, 196608 + k * 32768, 0, 0);
		push_cmd(CMD_LOAD, -8388608, 8388607, 10'h3FF, 10'h3FF);
		push_cmd(CMD_LOAD, 8388607, -8388608, 0, 0);
		push_cmd(CMD_LOAD, 0, 196608, 0, 0);
		push_cmd(CMD_TRY, 0, 0, 3, 3);
		push_cmd(CMD_TRY, 0, 0, 0, 12);
		push_cmd(CMD_TRY, 0, 0, 1023, 0);
		push_cmd(CMD_TRY, 0, 0, 0, 11);
		push_cmd(CMD_TRY, 0, 0, 9, 10);
		push_cmd(CMD_TRY, 0, 0, 0, 8);
		push_cmd(CMD_TRY, 0, 0, 1, 2);
		push_cmd(2'd3, 0, 0, 1, 2);
		push_cmd(CMD_TRY, 0, 0, 10, 9);
		drain();

		made = 0;
		ph = 0;
		while (made < 250) begin
			write_reg(CFG_THRESH, thr_set[ph % 5]);
			write_reg(CFG_MININL, min_set[ph % 5]);
			send_idle_pct = send_set[ph % 4];
			recv_stall_pct = stall_set[ph % 4];
			push_scan($urandom_range(6, 30), $urandom_range(10, 25), made);
			if (ph == 0) begin
				hold_req++;
				push_scan($urandom_range(6, 30), $urandom_range(10, 25), made);
			end
			if (ph == 2) begin
				while (pending_cmds.size() > 0 || offering || expected_lines.size() > 0)
					@(posedge clk);
				push_scan($urandom_range(6, 30), $urandom_range(10, 25), made);
			end
			drain();
			ph++;
		end
		write_reg(CFG_THRESH, 786);
		write_reg(CFG_MININL, 8);

		drain();
		if (errors == 0 && expected_lines.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/rle_pkg.sv
hw/rtl/rle_ram.sv
hw/rtl/rle_div.sv
hw/rtl/ransac_line_extraction.sv
test/tb_ransac_line_extraction.sv
